FILE: rtl/ray_depth_to_planar_depth_defines.svh
// ============================================================================
// ray_depth_to_planar_depth_defines.svh
// Assertion macros used by the ray_depth_to_planar_depth module.
// ============================================================================
`ifndef RAY_DEPTH_TO_PLANAR_DEPTH_DEFINES_SVH
`define RAY_DEPTH_TO_PLANAR_DEPTH_DEFINES_SVH

// Checked property, sampled on the rising clock edge and ignored during reset.
`define RDPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked property, sampled on the rising clock edge, also during reset.
`define RDPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/rdpd_pkg.sv
// ============================================================================
// rdpd_pkg
// Widths, constants and register indexes of the ray to planar depth block.
// ============================================================================
`default_nettype none

package rdpd_pkg;

    // Default coordinate width; pixel fields are never wider than the port.
    localparam int unsigned CoordBitsDefault = 12;
    localparam int unsigned CoordW           = 12;

    // Field widths.
    localparam int unsigned DepthW  = 16;
    localparam int unsigned CenterW = 16;
    localparam int unsigned InvFW   = 32;
    localparam int unsigned CfgW    = 32;
    localparam int unsigned CfgIdxW = 3;

    // Packed stream widths.
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 16;

    // Datapath widths.
    localparam int unsigned MagW   = 16;             // |pos - center|, Q.4
    localparam int unsigned ProdW  = MagW + InvFW;   // mag * inv_f
    localparam int unsigned FracSh = 20;             // Q.36 down to Q.16
    localparam int unsigned UW     = ProdW - FracSh; // ray factor, Q.16
    localparam int unsigned SqW    = 2 * UW;         // squared factor, Q.32
    localparam int unsigned RadW   = SqW + 2;        // radicand, Q.32
    localparam int unsigned RootW  = RadW / 2;       // square root, Q.16
    localparam int unsigned RemW   = RootW + 3;      // square root remainder
    localparam int unsigned SqrtSteps = RootW;
    localparam int unsigned DivRemW   = RootW + 1;   // division partial remainder
    localparam int unsigned DivSteps  = DepthW;

    // The constant one in Q.32 added under the square root.
    localparam logic [RadW-1:0] RadOne = RadW'(1) << 32;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CfgDepthMode = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgCenterX   = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgCenterY   = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgInvFocalX = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgInvFocalY = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/ray_depth_to_planar_depth.sv
// ============================================================================
// ray_depth_to_planar_depth
// Converts ray (euclidean) depth pixels to planar depth for a pinhole camera.
// ============================================================================
// Usage:
// Input items arrive on the slave stream (row, column and raw depth packed in
// i_s_tdata); one converted depth leaves on the master stream per item.
// Software programs the mode, the principal point (Q12.4) and the reciprocal
// focal lengths (Q0.32) through the write port while no item is in flight.
// In pass-through mode the depth is returned unchanged; in ray mode it is
// divided by the length of the normalized pixel ray.
// Each item passes the offset, multiply, square and sum stages, the bit-serial
// square root pipeline and the restoring divider pipeline, and then the output
// register.
// Throughput is one item per cycle while the receiver takes results.
// When the receiver stalls, one further result is caught in a skid register
// and the whole pipeline then holds; o_s_tready drops only in that case.
// Reset clears all valid bits and the configuration registers; the data
// registers keep whatever they held.
// ============================================================================
`default_nettype none

module ray_depth_to_planar_depth #(
    parameter int unsigned COORD_BITS = rdpd_pkg::CoordBitsDefault
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration write port.
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [rdpd_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire logic [rdpd_pkg::CfgW-1:0]        i_cfg_data,
    // Input stream.
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // Fields from bit 0: pixel_row[11:0], pixel_col[23:12], depth_raw[39:24].
    input  wire logic [rdpd_pkg::InDataW-1:0]     i_s_tdata,
    // Output stream.
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // Fields from bit 0: depth_out[15:0].
    output logic [rdpd_pkg::OutDataW-1:0]         o_m_tdata
);

    `include "ray_depth_to_planar_depth_defines.svh"

    localparam int unsigned CoordW  = rdpd_pkg::CoordW;
    localparam int unsigned UsedCB  = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
    localparam logic [CoordW-1:0] CoordMask = CoordW'((1 << UsedCB) - 1);
    localparam int unsigned DepthW  = rdpd_pkg::DepthW;
    localparam int unsigned MagW    = rdpd_pkg::MagW;
    localparam int unsigned ProdW   = rdpd_pkg::ProdW;
    localparam int unsigned UW      = rdpd_pkg::UW;
    localparam int unsigned SqW     = rdpd_pkg::SqW;
    localparam int unsigned RadW    = rdpd_pkg::RadW;
    localparam int unsigned RootW   = rdpd_pkg::RootW;

    // Configuration registers.
    logic                          r_depth_mode;
    logic [rdpd_pkg::CenterW-1:0]  r_center_x;
    logic [rdpd_pkg::CenterW-1:0]  r_center_y;
    logic [rdpd_pkg::InvFW-1:0]    r_inv_focal_x;
    logic [rdpd_pkg::InvFW-1:0]    r_inv_focal_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_mode  <= 1'b0;
            r_center_x    <= '0;
            r_center_y    <= '0;
            r_inv_focal_x <= '0;
            r_inv_focal_y <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rdpd_pkg::CfgDepthMode: r_depth_mode  <= i_cfg_data[0];
                rdpd_pkg::CfgCenterX:   r_center_x    <= i_cfg_data[rdpd_pkg::CenterW-1:0];
                rdpd_pkg::CfgCenterY:   r_center_y    <= i_cfg_data[rdpd_pkg::CenterW-1:0];
                rdpd_pkg::CfgInvFocalX: r_inv_focal_x <= i_cfg_data;
                rdpd_pkg::CfgInvFocalY: r_inv_focal_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline advance: everything moves unless the skid register is holding.
    logic r_skid_valid;
    logic w_en;
    assign w_en       = !r_skid_valid;
    assign o_s_tready = w_en;

    // Stage A: pixel position in Q.4 and its distance from the principal point.
    logic [CoordW-1:0] w_row;
    logic [CoordW-1:0] w_col;
    logic [MagW-1:0]   w_pos_x;
    logic [MagW-1:0]   w_pos_y;
    logic [MagW-1:0]   w_mag_x;
    logic [MagW-1:0]   w_mag_y;

    assign w_row   = i_s_tdata[CoordW-1:0] & CoordMask;
    assign w_col   = i_s_tdata[2*CoordW-1:CoordW] & CoordMask;
    assign w_pos_x = MagW'({w_col, 4'b0000});
    assign w_pos_y = MagW'({w_row, 4'b0000});
    assign w_mag_x = (w_pos_x >= r_center_x) ? (w_pos_x - r_center_x) : (r_center_x - w_pos_x);
    assign w_mag_y = (w_pos_y >= r_center_y) ? (w_pos_y - r_center_y) : (r_center_y - w_pos_y);

    logic              r_a_vld;
    logic [MagW-1:0]   r_a_mag_x;
    logic [MagW-1:0]   r_a_mag_y;
    logic [DepthW-1:0] r_a_dep;

    // Stage B: ray factors in Q.16.
    logic [ProdW-1:0]  w_prod_x;
    logic [ProdW-1:0]  w_prod_y;
    logic              r_b_vld;
    logic [UW-1:0]     r_b_ux;
    logic [UW-1:0]     r_b_uy;
    logic [DepthW-1:0] r_b_dep;

    assign w_prod_x = ProdW'(r_a_mag_x) * ProdW'(r_inv_focal_x);
    assign w_prod_y = ProdW'(r_a_mag_y) * ProdW'(r_inv_focal_y);

    // Stage C: squared factors in Q.32.
    logic              r_c_vld;
    logic [SqW-1:0]    r_c_sq_x;
    logic [SqW-1:0]    r_c_sq_y;
    logic [DepthW-1:0] r_c_dep;

    // Stage D: squared ray length in Q.32.
    logic              r_d_vld;
    logic [RadW-1:0]   r_d_rad;
    logic [DepthW-1:0] r_d_dep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_s_tvalid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_mag_x <= w_mag_x;
            r_a_mag_y <= w_mag_y;
            r_a_dep   <= i_s_tdata[rdpd_pkg::InDataW-1 -: DepthW];
            r_b_ux    <= w_prod_x[ProdW-1:rdpd_pkg::FracSh];
            r_b_uy    <= w_prod_y[ProdW-1:rdpd_pkg::FracSh];
            r_b_dep   <= r_a_dep;
            r_c_sq_x  <= SqW'(r_b_ux) * SqW'(r_b_ux);
            r_c_sq_y  <= SqW'(r_b_uy) * SqW'(r_b_uy);
            r_c_dep   <= r_b_dep;
            r_d_rad   <= RadW'(r_c_sq_x) + RadW'(r_c_sq_y) + rdpd_pkg::RadOne;
            r_d_dep   <= r_c_dep;
        end
    end

    // Square root of the squared ray length.
    logic              w_sq_vld;
    logic [RootW-1:0]  w_sq_root;
    logic [DepthW-1:0] w_sq_dep;

    rdpd_isqrt_pipe u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_d_vld),
        .i_rad   (r_d_rad),
        .i_dep   (r_d_dep),
        .o_vld   (w_sq_vld),
        .o_root  (w_sq_root),
        .o_dep   (w_sq_dep)
    );

    // Depth scaled by the reciprocal ray length.
    logic              w_dv_vld;
    logic [DepthW-1:0] w_dv_quo;
    logic [DepthW-1:0] w_dv_dep;

    rdpd_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_dvs   (w_sq_root),
        .i_dep   (w_sq_dep),
        .o_vld   (w_dv_vld),
        .o_quo   (w_dv_quo),
        .o_dep   (w_dv_dep)
    );

    // Mode select for the item leaving the pipeline.
    logic              w_exit;
    logic [DepthW-1:0] w_exit_data;
    assign w_exit      = w_en && w_dv_vld;
    assign w_exit_data = r_depth_mode ? w_dv_quo : w_dv_dep;

    // Output register with a skid register behind it.
    logic              r_out_valid;
    logic [DepthW-1:0] r_out_data;
    logic [DepthW-1:0] r_skid_data;
    logic              w_out_free;
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid  <= r_skid_valid || w_exit;
            r_skid_valid <= 1'b0;
        end else if (w_exit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : w_exit_data;
        end else if (w_exit) begin
            r_skid_data <= w_exit_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // The skid register only holds an item while the output register is full.
    `RDPD_ASSERT(a_skid_behind_out, r_skid_valid |-> r_out_valid, "skid full with empty output")
    // A taken output with a held item moves the held item forward.
    `RDPD_ASSERT(a_skid_drains, (r_out_valid && i_m_tready && r_skid_valid) |=> (r_out_valid && !r_skid_valid), "skid item not forwarded")
    // The ray length is at least one, so the root is at least one in Q.16.
    `RDPD_ASSERT(a_root_min, w_sq_vld |-> (w_sq_root[RootW-1:16] != '0), "square root below one")
    // Converted depth never exceeds the raw depth.
    `RDPD_ASSERT(a_quo_bound, w_dv_vld |-> (w_dv_quo <= w_dv_dep), "converted depth above raw depth")

endmodule

`default_nettype wire

FILE: rtl/rdpd_isqrt_pipe.sv
// ============================================================================
// rdpd_isqrt_pipe
// Pipelined integer square root, one result bit per stage, with the depth
// value carried alongside.
// ============================================================================
`default_nettype none

module rdpd_isqrt_pipe (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_vld,
    input  wire logic [rdpd_pkg::RadW-1:0]       i_rad,
    input  wire logic [rdpd_pkg::DepthW-1:0]     i_dep,
    output logic                                 o_vld,
    output logic [rdpd_pkg::RootW-1:0]           o_root,
    output logic [rdpd_pkg::DepthW-1:0]          o_dep
);

    localparam int unsigned Steps = rdpd_pkg::SqrtSteps;
    localparam int unsigned RadW  = rdpd_pkg::RadW;
    localparam int unsigned RootW = rdpd_pkg::RootW;
    localparam int unsigned RemW  = rdpd_pkg::RemW;
    localparam int unsigned DepW  = rdpd_pkg::DepthW;

    // Stage registers; remainder and radicand are not needed after the last stage.
    logic            r_vld  [0:Steps-1];
    logic [RootW-1:0] r_root [0:Steps-1];
    logic [DepW-1:0] r_dep  [0:Steps-1];
    logic [RemW-1:0] r_rem  [0:Steps-2];
    logic [RadW-1:0] r_rad  [0:Steps-2];

    for (genvar k = 0; k < Steps; k++) begin : g_stage
        logic             vld_in;
        logic [RemW-1:0]  rem_in;
        logic [RootW-1:0] root_in;
        logic [RadW-1:0]  rad_in;
        logic [DepW-1:0]  dep_in;
        logic [RemW-1:0]  cur;
        logic [RemW-1:0]  trial;
        logic             ge;
        logic [RemW-1:0]  n_rem;
        logic [RootW-1:0] n_root;

        // Stage inputs come from the ports or from the stage before.
        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign dep_in  = i_dep;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign dep_in  = r_dep[k-1];
        end

        // Bring down the next two radicand bits and try the next root bit.
        assign cur    = {rem_in[RemW-3:0], rad_in[RadW-1 -: 2]};
        assign trial  = RemW'({root_in, 2'b01});
        assign ge     = (cur >= trial);
        assign n_rem  = ge ? (cur - trial) : cur;
        assign n_root = {root_in[RootW-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= n_root;
                r_dep[k]  <= dep_in;
            end
        end

        if (k < Steps - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_rad[k] <= {rad_in[RadW-3:0], 2'b00};
                end
            end
        end
    end

    assign o_vld  = r_vld[Steps-1];
    assign o_root = r_root[Steps-1];
    assign o_dep  = r_dep[Steps-1];

endmodule

`default_nettype wire

FILE: rtl/rdpd_div_pipe.sv
// ============================================================================
// rdpd_div_pipe
// Pipelined restoring divider for (depth << 16) / root, one quotient bit per
// stage, with the raw depth carried alongside.
// ============================================================================
`default_nettype none

module rdpd_div_pipe (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_vld,
    input  wire logic [rdpd_pkg::RootW-1:0]      i_dvs,
    input  wire logic [rdpd_pkg::DepthW-1:0]     i_dep,
    output logic                                 o_vld,
    output logic [rdpd_pkg::DepthW-1:0]          o_quo,
    output logic [rdpd_pkg::DepthW-1:0]          o_dep
);

    localparam int unsigned Steps = rdpd_pkg::DivSteps;
    localparam int unsigned DvsW  = rdpd_pkg::RootW;
    localparam int unsigned RemW  = rdpd_pkg::DivRemW;
    localparam int unsigned DepW  = rdpd_pkg::DepthW;

    // Stage registers; remainder and divisor are not needed after the last stage.
    logic            r_vld [0:Steps-1];
    logic [DepW-1:0] r_quo [0:Steps-1];
    logic [DepW-1:0] r_dep [0:Steps-1];
    logic [RemW-1:0] r_rem [0:Steps-2];
    logic [DvsW-1:0] r_dvs [0:Steps-2];

    for (genvar k = 0; k < Steps; k++) begin : g_stage
        logic            vld_in;
        logic [RemW-1:0] rem_in;
        logic [DepW-1:0] quo_in;
        logic [DvsW-1:0] dvs_in;
        logic [DepW-1:0] dep_in;
        logic [RemW-1:0] sh;
        logic            ge;
        logic [RemW-1:0] n_rem;
        logic [DepW-1:0] n_quo;

        // The depth is below the divisor, so it is the first partial remainder.
        if (k == 0) begin : g_first
            assign vld_in = i_vld;
            assign rem_in = RemW'(i_dep);
            assign quo_in = '0;
            assign dvs_in = i_dvs;
            assign dep_in = i_dep;
        end else begin : g_next
            assign vld_in = r_vld[k-1];
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign dvs_in = r_dvs[k-1];
            assign dep_in = r_dep[k-1];
        end

        // Shift in a zero dividend bit and subtract the divisor where it fits.
        assign sh    = {rem_in[RemW-2:0], 1'b0};
        assign ge    = (sh >= RemW'(dvs_in));
        assign n_rem = ge ? (sh - RemW'(dvs_in)) : sh;
        assign n_quo = {quo_in[DepW-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= n_quo;
                r_dep[k] <= dep_in;
            end
        end

        if (k < Steps - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_dvs[k] <= dvs_in;
                end
            end
        end
    end

    assign o_vld = r_vld[Steps-1];
    assign o_quo = r_quo[Steps-1];
    assign o_dep = r_dep[Steps-1];

endmodule

`default_nettype wire
